### rtl/core/evr_pkg.sv
`timescale 1ns / 1ps

package evr_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int ANGLE_REG_W    = 16;
  localparam int COORD_W        = 32;
  localparam int TRIG_W         = 16;
  localparam int NUM_CELLS      = 3;
  localparam int REG_INDEX_W    = 2;

  localparam logic [REG_INDEX_W-1:0] REG_ANGLE_X = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [REG_INDEX_W-1:0] REG_ANGLE_Z = 2'd2;

  // Odd-power coefficients of the sine polynomial, unsigned Q30
  localparam logic [31:0] POLY_C1 = 32'd1686629713;
  localparam logic [31:0] POLY_C3 = 32'd693598668;
  localparam logic [31:0] POLY_C5 = 32'd85569306;
  localparam logic [31:0] POLY_C7 = 32'd5026996;
  localparam logic [31:0] POLY_C9 = 32'd172273;

  // Coordinates travelling down the chain: (u, v) is the pair a cell rotates,
  // w passes through untouched.
  typedef struct packed {
    logic signed [COORD_W-1:0] u;
    logic signed [COORD_W-1:0] v;
    logic signed [COORD_W-1:0] w;
    logic                      sat;
  } evr_vec_t;

  // One sine or cosine value from the trig sequencer
  typedef struct packed {
    logic                     we;
    logic [REG_INDEX_W-1:0]   dest;
    logic                     is_cos;
    logic signed [TRIG_W-1:0] val;
  } trig_wr_t;

  // Load strobes seen by one cell
  typedef struct packed {
    logic                     sin_we;
    logic                     cos_we;
    logic signed [TRIG_W-1:0] val;
  } trig_load_t;

endpackage

### rtl/core/evr_if.sv
`timescale 1ns / 1ps

interface evr_point_if import evr_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic signed [COORD_W-1:0] pz;

  modport source (output valid, output px, output py, output pz, input ready);
  modport sink   (input valid, input px, input py, input pz, output ready);
endinterface

interface evr_result_if import evr_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] rx;
  logic signed [COORD_W-1:0] ry;
  logic signed [COORD_W-1:0] rz;
  logic                      saturated;

  modport source (output valid, output rx, output ry, output rz, output saturated,
                  input ready);
  modport sink   (input valid, input rx, input ry, input rz, input saturated,
                  output ready);
endinterface

### rtl/core/euler_vector_rotate_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload                      Request taken when
// point     in         px, py, pz (Q16.16)          valid && ready
// result    out        rx, ry, rz, saturated        valid && ready
// config    in         reg_index, write_data        write_enable
//
// One point per cycle while the sequencer is idle and the chain is not stalled;
// each passes three rotation cells of two stages each and the output register.
// After reset and after every angle write the sine/cosine sequencer computes
// six values (seven sequencer steps each); point.ready is low meanwhile.
// A stalled result holds the chain; bubbles inside it still fill.

module euler_vector_rotate_core import evr_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  evr_point_if.sink              point,
  evr_result_if.source           result,
  input  logic                   write_enable,
  input  logic [REG_INDEX_W-1:0] reg_index,
  input  logic [ANGLE_REG_W-1:0] write_data
);

  logic [ANGLE_REG_W-1:0] angle [NUM_CELLS];
  logic                   busy;
  trig_wr_t               twr;
  trig_load_t             load  [NUM_CELLS];

  evr_vec_t c_in        [NUM_CELLS];
  evr_vec_t c_out       [NUM_CELLS];
  logic     c_in_valid  [NUM_CELLS];
  logic     c_in_go     [NUM_CELLS];
  logic     c_out_valid [NUM_CELLS];
  logic     c_out_go    [NUM_CELLS];

  logic     res_valid;
  evr_vec_t res;
  logic     open_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle[0] <= '0;
      angle[1] <= '0;
      angle[2] <= '0;
    end else if (write_enable) begin
      unique case (reg_index)
        REG_ANGLE_X: angle[0] <= write_data;
        REG_ANGLE_Y: angle[1] <= write_data;
        REG_ANGLE_Z: angle[2] <= write_data;
        default: ;
      endcase
    end
  end

  evr_trig #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_trig (
    .clk     (clk),
    .rst     (rst),
    .restart (write_enable),
    .angle   (angle),
    .busy    (busy),
    .wr      (twr)
  );

  assign open_in     = !busy && !write_enable;
  assign point.ready = c_in_go[0] && open_in;
  assign c_in_valid[0] = point.valid && open_in;
  // First cell turns about x: (y, z) rotate, x rides along
  assign c_in[0] = '{u: point.py, v: point.pz, w: point.px, sat: 1'b0};

  genvar i;
  generate
    for (i = 0; i < NUM_CELLS; i++) begin : g_cell
      always_comb begin
        load[i].sin_we = twr.we && !twr.is_cos && (twr.dest == REG_INDEX_W'(i));
        load[i].cos_we = twr.we &&  twr.is_cos && (twr.dest == REG_INDEX_W'(i));
        load[i].val    = twr.val;
      end

      evr_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .load      (load[i]),
        .in_valid  (c_in_valid[i]),
        .in_data   (c_in[i]),
        .in_go     (c_in_go[i]),
        .out_valid (c_out_valid[i]),
        .out_data  (c_out[i]),
        .out_go    (c_out_go[i])
      );

      // Rotate the tuple so the next axis pair lands on (u, v)
      if (i > 0) begin : g_link
        assign c_in[i] = '{u: c_out[i-1].v, v: c_out[i-1].w, w: c_out[i-1].u,
                           sat: c_out[i-1].sat};
        assign c_in_valid[i] = c_out_valid[i-1];
        assign c_out_go[i-1] = c_in_go[i];
      end
    end
  endgenerate

  assign c_out_go[NUM_CELLS-1] = !res_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (c_out_go[NUM_CELLS-1]) begin
      res_valid <= c_out_valid[NUM_CELLS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (c_out_go[NUM_CELLS-1] && c_out_valid[NUM_CELLS-1]) begin
      res <= c_out[NUM_CELLS-1];
    end
  end

  assign result.valid     = res_valid;
  assign result.rx        = res.u;
  assign result.ry        = res.v;
  assign result.rz        = res.w;
  assign result.saturated = res.sat;

endmodule

### rtl/core/evr_trig.sv
`timescale 1ns / 1ps

module evr_trig import evr_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   restart,
  input  logic [ANGLE_REG_W-1:0] angle [NUM_CELLS],
  output logic                   busy,
  output trig_wr_t               wr
);

  localparam int QB = ANGLE_BITS - 2;
  localparam logic [2:0] JOB_LAST = 3'(2 * NUM_CELLS - 1);

  localparam logic [2:0] ST_SQUARE = 3'd0;
  localparam logic [2:0] ST_C7     = 3'd1;
  localparam logic [2:0] ST_C5     = 3'd2;
  localparam logic [2:0] ST_C3     = 3'd3;
  localparam logic [2:0] ST_C1     = 3'd4;
  localparam logic [2:0] ST_SCALE  = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  typedef enum logic [1:0] {
    T_IDLE = 2'b01,
    T_RUN  = 2'b10
  } trig_state_t;

  trig_state_t state;
  logic [2:0]  job;
  logic [2:0]  step;
  logic [30:0] t2;
  logic [31:0] p;

  logic [ANGLE_REG_W+ANGLE_BITS-1:0] ang_wide;
  logic [ANGLE_BITS-1:0]             ang;
  logic [1:0]                        quad;
  logic [QB:0]                       q;
  logic [30:0]                       t;
  logic [30:0]                       mul_a;
  logic [31:0]                       mul_b;
  logic [62:0]                       prod;
  logic [31:0]                       p_next;
  logic [17:0]                       rnd;
  logic [14:0]                       mag;

  function automatic logic [31:0] poly_coef(input logic [2:0] s);
    logic [31:0] c;
    case (s)
      ST_C7:   c = POLY_C7;
      ST_C5:   c = POLY_C5;
      ST_C3:   c = POLY_C3;
      default: c = POLY_C1;
    endcase
    return c;
  endfunction

  // Odd jobs are cosines: sin of the angle plus a quarter turn
  always_comb begin
    ang_wide = {{ANGLE_BITS{1'b0}}, angle[job[2:1]]};
    ang      = ang_wide[ANGLE_BITS-1:0]
             + (job[0] ? (ANGLE_BITS'(1) << QB) : ANGLE_BITS'(0));
    quad     = ang[ANGLE_BITS-1 -: 2];
    q        = quad[0] ? ({1'b1, {QB{1'b0}}} - {1'b0, ang[QB-1:0]})
                       : {1'b0, ang[QB-1:0]};
    t        = 31'(q) << (30 - QB);
  end

  always_comb begin
    mul_a = (step == ST_SQUARE || step == ST_SCALE) ? t : t2;
    if (step == ST_SQUARE) begin
      mul_b = {1'b0, t};
    end else if (step == ST_C7) begin
      mul_b = POLY_C9;
    end else begin
      mul_b = p;
    end
    prod = 63'(mul_a) * 63'(mul_b);
    if (step == ST_SCALE) begin
      p_next = prod[61:30];
    end else begin
      p_next = poly_coef(step) - prod[61:30];
    end
  end

  always_comb begin
    rnd       = 18'(p[31:15]) + 18'(p[14]);
    mag       = (rnd > 18'd32767) ? 15'h7FFF : rnd[14:0];
    wr.we     = (state == T_RUN) && (step == ST_OUT);
    wr.dest   = job[2:1];
    wr.is_cos = job[0];
    wr.val    = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  assign busy = (state == T_RUN);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= T_RUN;
      job   <= '0;
      step  <= ST_SQUARE;
    end else begin
      unique case (state)
        T_IDLE: begin
          state <= T_IDLE;
        end
        T_RUN: begin
          if (step == ST_OUT) begin
            step <= ST_SQUARE;
            if (job == JOB_LAST) begin
              state <= T_IDLE;
            end else begin
              job <= job + 3'd1;
            end
          end else begin
            step <= step + 3'd1;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (step == ST_SQUARE) begin
      t2 <= prod[60:30];
    end else if (step != ST_OUT) begin
      p <= p_next;
    end
  end

endmodule

### rtl/core/evr_cell.sv
`timescale 1ns / 1ps

module evr_cell import evr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  trig_load_t load,
  input  logic       in_valid,
  input  evr_vec_t   in_data,
  output logic       in_go,
  output logic       out_valid,
  output evr_vec_t   out_data,
  input  logic       out_go
);

  localparam int PW = COORD_W + TRIG_W;

  typedef struct packed {
    logic signed [PW-1:0]      uc;
    logic signed [PW-1:0]      vs;
    logic signed [PW-1:0]      us;
    logic signed [PW-1:0]      vc;
    logic signed [COORD_W-1:0] w;
    logic                      sat;
  } prod_t;

  logic signed [TRIG_W-1:0] sin_v;
  logic signed [TRIG_W-1:0] cos_v;
  logic                     v1;
  prod_t                    s1;
  prod_t                    s1_next;
  logic                     go1;
  logic                     go2;
  logic signed [PW:0]       sum_a;
  logic signed [PW:0]       sum_b;
  logic [COORD_W:0]         res_a;
  logic [COORD_W:0]         res_b;

  // Round half up, then clip to the coordinate range; top bit flags a clip
  function automatic logic [COORD_W:0] round_sat(input logic signed [PW:0] s);
    logic signed [PW:0] r;
    logic [COORD_W:0]   o;
    r = (s + (PW+1)'(1 << (TRIG_W - 2))) >>> (TRIG_W - 1);
    if (r[PW:COORD_W-1] == '0 || r[PW:COORD_W-1] == '1) begin
      o = {1'b0, r[COORD_W-1:0]};
    end else if (r[PW]) begin
      o = {1'b1, 1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      o = {1'b1, 1'b0, {(COORD_W-1){1'b1}}};
    end
    return o;
  endfunction

  assign go2   = !out_valid || out_go;
  assign go1   = !v1 || go2;
  assign in_go = go1;

  always_comb begin
    s1_next.uc  = PW'($signed(in_data.u)) * PW'(cos_v);
    s1_next.vs  = PW'($signed(in_data.v)) * PW'(sin_v);
    s1_next.us  = PW'($signed(in_data.u)) * PW'(sin_v);
    s1_next.vc  = PW'($signed(in_data.v)) * PW'(cos_v);
    s1_next.w   = in_data.w;
    s1_next.sat = in_data.sat;
  end

  always_comb begin
    sum_a = (PW+1)'($signed(s1.uc)) - (PW+1)'($signed(s1.vs));
    sum_b = (PW+1)'($signed(s1.us)) + (PW+1)'($signed(s1.vc));
    res_a = round_sat(sum_a);
    res_b = round_sat(sum_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (go1) begin
        v1 <= in_valid;
      end
      if (go2) begin
        out_valid <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load.sin_we) begin
      sin_v <= load.val;
    end
    if (load.cos_we) begin
      cos_v <= load.val;
    end
    if (go1 && in_valid) begin
      s1 <= s1_next;
    end
    if (go2 && v1) begin
      out_data.u   <= res_a[COORD_W-1:0];
      out_data.v   <= res_b[COORD_W-1:0];
      out_data.w   <= s1.w;
      out_data.sat <= s1.sat | res_a[COORD_W] | res_b[COORD_W];
    end
  end

endmodule

### sim/euler_vector_rotate_core_test.sv
`timescale 1ns / 1ps

module euler_vector_rotate_core_test;
  import evr_pkg::*;

  localparam int QUAD_BITS = ANGLE_BITS_DEF - 2;
  localparam int TRIG_FRAC = TRIG_W - 1;
  localparam logic [ANGLE_REG_W-1:0] QUARTER_TURN = 16'd16384;
  localparam logic [REG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;
  localparam int RANDOM_PER_PHASE = 138;
  localparam int RANDOM_PHASES = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct {
    logic signed [COORD_W-1:0] rx;
    logic signed [COORD_W-1:0] ry;
    logic signed [COORD_W-1:0] rz;
    logic                      sat;
  } rotated_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic write_enable = 1'b0;
  logic [REG_INDEX_W-1:0] reg_index = '0;
  logic [ANGLE_REG_W-1:0] write_data = '0;

  evr_point_if point_ch ();
  evr_result_if result_ch ();

  euler_vector_rotate_core dut (
    .clk          (clk),
    .rst          (rst),
    .point        (point_ch),
    .result       (result_ch),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Angles as the block should hold them
  logic [ANGLE_REG_W-1:0] ang_x = '0;
  logic [ANGLE_REG_W-1:0] ang_y = '0;
  logic [ANGLE_REG_W-1:0] ang_z = '0;

  point_t   pending_q[$];
  rotated_t rotated_q[$];
  int       mismatches = 0;

  function automatic longint unsigned quarter_sine(longint unsigned q);
    longint unsigned t, t2, p;
    t  = q << (30 - QUAD_BITS);
    t2 = (t * t) >> 30;
    p  = POLY_C7 - ((t2 * POLY_C9) >> 30);
    p  = POLY_C5 - ((t2 * p) >> 30);
    p  = POLY_C3 - ((t2 * p) >> 30);
    p  = POLY_C1 - ((t2 * p) >> 30);
    p  = (t * p) >> 30;
    p  = (p + (64'd1 << (TRIG_FRAC - 1))) >> TRIG_FRAC;
    if (p > 64'd32767) p = 64'd32767;
    return p;
  endfunction

  function automatic longint sine_q15(logic [ANGLE_REG_W-1:0] a);
    longint unsigned mag;
    logic [1:0] quad;
    longint unsigned frac;
    quad = a[ANGLE_REG_W-1 -: 2];
    frac = 64'(a[QUAD_BITS-1:0]);
    // mirror the quarter wave in odd quadrants, negate in the lower half
    if (quad[0]) mag = quarter_sine((64'd1 << QUAD_BITS) - frac);
    else mag = quarter_sine(frac);
    if (quad[1]) return -longint'(mag);
    return longint'(mag);
  endfunction

  function automatic longint round_clip(longint sum, inout bit clip);
    longint r;
    r = (sum + (64'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
    if (r > I32_MAX) begin
      clip = 1'b1;
      r = I32_MAX;
    end else if (r < I32_MIN) begin
      clip = 1'b1;
      r = I32_MIN;
    end
    return r;
  endfunction

  function automatic void turn_pair(inout longint u, inout longint v,
                                    input logic [ANGLE_REG_W-1:0] ang, inout bit clip);
    logic [ANGLE_REG_W-1:0] cos_ang;
    longint s, c, nu, nv;
    cos_ang = ang + QUARTER_TURN;
    s  = sine_q15(ang);
    c  = sine_q15(cos_ang);
    nu = round_clip(u * c - v * s, clip);
    nv = round_clip(u * s + v * c, clip);
    u  = nu;
    v  = nv;
  endfunction

  function automatic rotated_t rotate_point(point_t p);
    longint x, y, z;
    bit clip;
    rotated_t r;
    x = longint'(p.x);
    y = longint'(p.y);
    z = longint'(p.z);
    clip = 1'b0;
    turn_pair(y, z, ang_x, clip);
    turn_pair(z, x, ang_y, clip);
    turn_pair(x, y, ang_z, clip);
    r.rx  = x[COORD_W-1:0];
    r.ry  = y[COORD_W-1:0];
    r.rz  = z[COORD_W-1:0];
    r.sat = clip;
    return r;
  endfunction

  // Mostly a random gap of idling, with the odd long stretch of none
  function automatic int pick_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) calm = $urandom_range(16, 64);
    return $urandom_range(0, 7);
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    int pick;
    logic signed [19:0] narrow;
    pick = $urandom_range(0, 9);
    narrow = 20'($urandom);
    if (pick < 4) return $urandom;
    if (pick < 7) return COORD_W'(narrow);
    case ($urandom_range(0, 4))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'sh00010000;
      3: return 32'shFFFF0000;
      default: return 32'sh7FFF0000 + $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic queue_point(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic signed [COORD_W-1:0] z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    pending_q.push_back(p);
  endtask

  task automatic queue_directed();
    queue_point(32'sh00000000, 32'sh00000000, 32'sh00000000);
    queue_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    queue_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
    queue_point(32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000);
    queue_point(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
    queue_point(32'sh00000001, 32'shFFFFFFFF, 32'sh00000001);
    queue_point(32'sh00010000, 32'sh00000000, 32'sh00000000);
    queue_point(32'sh00000000, 32'sh00010000, 32'sh00000000);
    queue_point(32'sh00000000, 32'sh00000000, 32'sh00010000);
    queue_point(32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF);
    queue_point(32'sh7FFF8000, 32'sh80008000, 32'sh12345678);
    queue_point(32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F);
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) queue_point(rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || point_ch.valid || rotated_q.size() != 0)
      @(negedge clk);
  endtask

  // Write all three angles, then junk to the spare index, which must be ignored
  task automatic program_angles(input logic [ANGLE_REG_W-1:0] ax,
                                input logic [ANGLE_REG_W-1:0] ay,
                                input logic [ANGLE_REG_W-1:0] az);
    logic [ANGLE_REG_W-1:0] junk;
    junk = ANGLE_REG_W'($urandom_range(0, 65535));
    drain();
    @(posedge clk);
    write_enable <= 1'b1;
    reg_index    <= REG_ANGLE_X;
    write_data   <= ax;
    ang_x = ax;
    @(posedge clk);
    reg_index  <= REG_ANGLE_Y;
    write_data <= ay;
    ang_y = ay;
    @(posedge clk);
    reg_index  <= REG_ANGLE_Z;
    write_data <= az;
    ang_z = az;
    @(posedge clk);
    reg_index  <= REG_UNUSED;
    write_data <= junk;
    @(posedge clk);
    write_enable <= 1'b0;
    @(negedge clk);
  endtask

  // Request driver
  int     send_gap = 0;
  int     send_calm = 0;
  logic   drv_busy;
  point_t drv_item;
  point_t drv_taken;

  always @(posedge clk) begin
    if (rst) begin
      point_ch.valid <= 1'b0;
      send_gap = pick_gap(send_calm);
    end else begin
      drv_busy   = point_ch.valid;
      drv_item.x = point_ch.px;
      drv_item.y = point_ch.py;
      drv_item.z = point_ch.pz;
      if (point_ch.valid && point_ch.ready) begin
        drv_taken = pending_q.pop_front();
        rotated_q.push_back(rotate_point(drv_taken));
        send_gap = pick_gap(send_calm);
        drv_busy = 1'b0;
      end
      if (!drv_busy) begin
        if (send_gap > 0 || pending_q.size() == 0) begin
          if (send_gap > 0) send_gap--;
          // idle payload carries junk
          drv_item.x = $urandom;
          drv_item.y = $urandom;
          drv_item.z = $urandom;
        end else begin
          drv_item = pending_q[0];
          drv_busy = 1'b1;
        end
      end
      point_ch.valid <= drv_busy;
      point_ch.px    <= drv_item.x;
      point_ch.py    <= drv_item.y;
      point_ch.pz    <= drv_item.z;
    end
  end

  // Result monitor
  int       recv_gap = 0;
  int       recv_calm = 0;
  rotated_t want;

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (rotated_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result %h %h %h %b", result_ch.rx, result_ch.ry,
                     result_ch.rz, result_ch.saturated);
        end else begin
          want = rotated_q.pop_front();
          if (result_ch.rx !== want.rx || result_ch.ry !== want.ry ||
              result_ch.rz !== want.rz || result_ch.saturated !== want.sat) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("mismatch: expected %h %h %h sat %b, got %h %h %h sat %b",
                       want.rx, want.ry, want.rz, want.sat, result_ch.rx, result_ch.ry,
                       result_ch.rz, result_ch.saturated);
          end
        end
        recv_gap = pick_gap(recv_calm);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  int quiet = 0;

  always @(posedge clk) begin
    if (rst || write_enable || (point_ch.valid && point_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("** euler_vector_rotate_core: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    point_ch.valid  = 1'b0;
    point_ch.px     = '0;
    point_ch.py     = '0;
    point_ch.pz     = '0;
    result_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset angles: identity rotation, cosine reads as just under one
    queue_directed();
    queue_random(RANDOM_PER_PHASE);

    program_angles(QUARTER_TURN, 16'd0, 16'd0);
    queue_random(RANDOM_PER_PHASE);
    program_angles(16'd0, QUARTER_TURN, 16'd0);
    queue_random(RANDOM_PER_PHASE);
    program_angles(16'd0, 16'd0, QUARTER_TURN);
    queue_random(RANDOM_PER_PHASE);
    program_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_random(RANDOM_PER_PHASE);

    // eighth turns push large points past the bounds
    program_angles(16'd8192, 16'd8192, 16'd8192);
    queue_directed();
    queue_random(RANDOM_PER_PHASE);

    program_angles(16'd32768, 16'd49152, 16'd1);
    queue_random(RANDOM_PER_PHASE);

    for (int i = 0; i < RANDOM_PHASES; i++) begin
      program_angles(ANGLE_REG_W'($urandom_range(0, 65535)),
                     ANGLE_REG_W'($urandom_range(0, 65535)),
                     ANGLE_REG_W'($urandom_range(0, 65535)));
      queue_random(RANDOM_PER_PHASE);
    end

    drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && rotated_q.size() == 0) begin
      $display("** euler_vector_rotate_core: PASSED **");
    end else begin
      $display("** euler_vector_rotate_core: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/evr_pkg.sv
rtl/core/evr_if.sv
rtl/core/evr_trig.sv
rtl/core/evr_cell.sv
rtl/core/euler_vector_rotate_core.sv
sim/euler_vector_rotate_core_test.sv
